### src/utb_pkg.sv
// shared constants, register indexes and the arc-cosine entry function
// for the ultrasonic bearing block; no dependencies
`timescale 1ns / 1ps
package utb_pkg;

    // field and register widths
    localparam int GAIN_W     = 24;
    localparam int THR_W      = 16;
    localparam int DB_W       = 15;
    localparam int OUT_W      = 15;
    localparam int ROM_W      = 15;
    localparam int ANGLE_W    = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_GAIN      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FRONT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SIDE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DEADBAND   = 4'd3;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST     = 24'd27682;
    localparam logic [THR_W-1:0]  THR_RST      = 16'd33;
    localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd1000;

    // quarter turn and output limit in centidegrees
    localparam logic signed [ANGLE_W-1:0] QUARTER_CD = 17'sd9000;
    localparam logic signed [OUT_W-1:0]   BEARING_MAX = 15'sd13500;

    // sign and threshold flags from the two side offsets
    typedef struct packed {
        logic front_lt;   // off02 below minus threshold_front
        logic side_lt;    // off12 below minus threshold_side
        logic neg02;      // off02 negative
        logic neg12;      // off12 negative
    } t_quad_flags;

    // arctangent of 2^-k in 1/65536 centidegree
    localparam longint ATAN_UNITS [20] = '{
        294912000, 174096719, 91987925, 46694507, 23437865,
        11730458, 5866610, 2933484, 1466765, 733385,
        366693, 183347, 91673, 45837, 22918,
        11459, 5730, 2865, 1432, 716
    };

    // arc-cosine of a q1.14 cosine in centidegrees, elaboration time only
    function automatic logic [ROM_W-1:0] acos_cd(input int c);
        longint          x;
        longint          y;
        longint          z;
        longint          t;
        longint          dx;
        longint          dy;
        longint          cd;
        longint unsigned v;
        longint unsigned res;
        longint unsigned rbit;
        int              k;
        x   = longint'(c) * 64'sd16384;
        v   = (64'd1 << 56) - longint'(x * x);
        res = 64'd0;
        // integer square root, two bits per step
        for (k = 0; k < 29; k++) begin
            rbit = 64'd1 << (56 - 2 * k);
            if (v >= res + rbit) begin
                v   = v - (res + rbit);
                res = (res >> 1) + rbit;
            end else begin
                res = res >> 1;
            end
        end
        y = longint'(res);
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 64'sd9000 * 64'sd65536;
        end
        // vectoring rotations
        for (k = 0; k < 20; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_UNITS[k];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_UNITS[k];
            end
        end
        cd = (z + 64'sd32768) >>> 16;
        if (cd < 0) begin
            cd = 0;
        end
        if (cd > 18000) begin
            cd = 18000;
        end
        return cd[ROM_W-1:0];
    endfunction

endpackage

### src/utb_acos_rom.sv
// arc-cosine lookup table with registered read
// depends on utb_pkg for the entry function
`timescale 1ns / 1ps
module utb_acos_rom #(
    parameter int ACOS_TABLE_SIZE = 1024
) (
    input  logic                                i_clk,
    input  logic [$clog2(ACOS_TABLE_SIZE)-1:0]  i_addr,
    output logic [utb_pkg::ROM_W-1:0]           o_data
);
    import utb_pkg::*;

    localparam int N1 = ACOS_TABLE_SIZE - 1;

    logic [ROM_W-1:0] w_rom [ACOS_TABLE_SIZE];
    logic [ROM_W-1:0] r_data;

    // entry g sits at the evenly spaced cosine for g
    for (genvar g = 0; g < ACOS_TABLE_SIZE; g++) begin : g_entry
        localparam int CI = -16384 + (32768 * g + N1 / 2) / N1;
        localparam logic [ROM_W-1:0] ENTRY = acos_cd(CI);
        assign w_rom[g] = ENTRY;
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

### src/ultrasonic_tdoa_bearing.sv
// bearing from three ultrasonic arrival timestamps
// depends on utb_pkg and utb_acos_rom
`timescale 1ns / 1ps
// usage
//   input: drive the three timestamps with start high; a word is taken at
//   every rising edge where start is high and busy is low. busy stays low,
//   so a new triple may be given in every cycle.
//   output: o_valid is high for one cycle with o_bearing_centideg and
//   o_turn_needed; results leave in input order, one per triple.
//   the receiver cannot stall the block; every result is shown exactly once.
//   config: i_cfg_valid with i_cfg_index and i_cfg_data writes a register
//   (0 gain, 1 front threshold, 2 side threshold, 3 deadband); o_cfg_ready
//   is always high; unknown indexes are dropped. write only while no
//   result is pending.
//   pipeline: input register, offset and gain multiply, ratio clamp, table
//   index multiply, registered table read, quadrant fix-up and output
//   register; one triple per cycle since every stage takes a new word
//   each cycle.
//   reset (i_rst_n low, synchronous) empties the pipeline and restores
//   the register defaults.
module ultrasonic_tdoa_bearing #(
    parameter int ACOS_TABLE_SIZE = 1024,
    parameter int TIME_WIDTH      = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [TIME_WIDTH-1:0]                 i_arrival_time_zero,
    input  logic [TIME_WIDTH-1:0]                 i_arrival_time_one,
    input  logic [TIME_WIDTH-1:0]                 i_arrival_time_two,
    output logic                                  o_valid,
    output logic signed [utb_pkg::OUT_W-1:0]      o_bearing_centideg,
    output logic                                  o_turn_needed,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [utb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [utb_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import utb_pkg::*;

    localparam int TW     = TIME_WIDTH;
    localparam int IDX_W  = $clog2(ACOS_TABLE_SIZE);
    localparam int PROD_W = TIME_WIDTH + 1 + GAIN_W + 1;
    localparam int SCL_W  = 17 + IDX_W;
    localparam int STAGES = 6;
    localparam logic signed [PROD_W-1:0] RATIO_MAX = PROD_W'(16384);
    localparam logic signed [PROD_W-1:0] RATIO_MIN = -RATIO_MAX;

    // configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic [THR_W-1:0]  r_thr_front;
    logic [THR_W-1:0]  r_thr_side;
    logic [DB_W-1:0]   r_deadband;

    // pipeline registers
    logic [STAGES-1:0]        r_vld;
    logic [TW-1:0]            r_t0;
    logic [TW-1:0]            r_t1;
    logic [TW-1:0]            r_t2;
    logic signed [PROD_W-1:0] r_prod;
    logic [15:0]              r_cos_u;
    logic [IDX_W-1:0]         r_idx;
    t_quad_flags              r_flags1;
    t_quad_flags              r_flags2;
    t_quad_flags              r_flags3;
    t_quad_flags              r_flags4;
    logic signed [OUT_W-1:0]  r_bearing;
    logic                     r_turn;

    logic [ROM_W-1:0] w_rom_q;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RST;
            r_thr_front <= THR_RST;
            r_thr_side  <= THR_RST;
            r_deadband  <= DEADBAND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RATIO_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_THRESHOLD_FRONT: r_thr_front <= i_cfg_data[THR_W-1:0];
                REG_THRESHOLD_SIDE:  r_thr_side  <= i_cfg_data[THR_W-1:0];
                REG_TURN_DEADBAND:   r_deadband  <= i_cfg_data[DB_W-1:0];
                default: ;
            endcase
        end
    end

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], start & ~busy};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        r_t0 <= i_arrival_time_zero;
        r_t1 <= i_arrival_time_one;
        r_t2 <= i_arrival_time_two;
    end

    // wrapping offsets, gain product and quadrant flags
    logic signed [TW-1:0] w_off01;
    logic signed [TW-1:0] w_off02;
    logic signed [TW-1:0] w_off12;
    logic signed [TW:0]   w_neg01;
    logic signed [TW:0]   w_front_sum;
    logic signed [TW:0]   w_side_sum;
    t_quad_flags          w_flags;

    always_comb begin
        w_off01     = $signed(r_t0 - r_t1);
        w_off02     = $signed(r_t0 - r_t2);
        w_off12     = $signed(r_t1 - r_t2);
        w_neg01     = -{w_off01[TW-1], w_off01};
        w_front_sum = {w_off02[TW-1], w_off02}
                    + $signed({{(TW + 1 - THR_W){1'b0}}, r_thr_front});
        w_side_sum  = {w_off12[TW-1], w_off12}
                    + $signed({{(TW + 1 - THR_W){1'b0}}, r_thr_side});
        w_flags.front_lt = w_front_sum[TW];
        w_flags.side_lt  = w_side_sum[TW];
        w_flags.neg02    = w_off02[TW-1];
        w_flags.neg12    = w_off12[TW-1];
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(w_neg01) * $signed({{(PROD_W - GAIN_W){1'b0}}, r_gain});
        r_flags1 <= w_flags;
    end

    // ratio scale and clamp to the cosine range, offset to unsigned
    logic signed [PROD_W-1:0] w_ratio;
    logic [15:0]              w_cos_u;

    always_comb begin
        w_ratio = r_prod >>> 10;
        if (w_ratio > RATIO_MAX) begin
            w_cos_u = 16'd32768;
        end else if (w_ratio < RATIO_MIN) begin
            w_cos_u = 16'd0;
        end else begin
            w_cos_u = w_ratio[15:0] + 16'd16384;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos_u  <= w_cos_u;
        r_flags2 <= r_flags1;
    end

    // nearest table index
    logic [SCL_W-1:0] w_scaled;

    assign w_scaled = SCL_W'(r_cos_u) * SCL_W'(ACOS_TABLE_SIZE - 1) + SCL_W'(16384);

    always_ff @(posedge i_clk) begin
        r_idx    <= w_scaled[15 +: IDX_W];
        r_flags3 <= r_flags2;
    end

    // table read
    utb_acos_rom #(
        .ACOS_TABLE_SIZE (ACOS_TABLE_SIZE)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (w_rom_q)
    );

    always_ff @(posedge i_clk) begin
        r_flags4 <= r_flags3;
    end

    // quadrant fix-up, halving and deadband test
    logic signed [ANGLE_W-1:0] w_a0;
    logic signed [ANGLE_W-1:0] w_a1;
    logic signed [ANGLE_W-1:0] w_a2;
    logic signed [ANGLE_W-1:0] w_half;
    logic signed [ANGLE_W-1:0] w_mag;

    always_comb begin
        w_a0 = $signed({{(ANGLE_W - ROM_W){1'b0}}, w_rom_q}) - QUARTER_CD;
        if (r_flags4.front_lt && r_flags4.neg12) begin
            w_a1 = w_a0 - QUARTER_CD;
        end else if (r_flags4.neg02 && r_flags4.side_lt) begin
            w_a1 = w_a0 + QUARTER_CD;
        end else begin
            w_a1 = w_a0;
        end
        // both offsets negative: push a further quarter away from zero
        if (r_flags4.neg02 && r_flags4.neg12) begin
            if (w_a1 > 0) begin
                w_a2 = w_a1 + QUARTER_CD;
            end else begin
                w_a2 = w_a1 - QUARTER_CD;
            end
        end else begin
            w_a2 = w_a1;
        end
        if (w_a2 < 0) begin
            w_half = -((-w_a2) >>> 1);
            w_mag  = (-w_a2) >>> 1;
        end else begin
            w_half = w_a2 >>> 1;
            w_mag  = w_a2 >>> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bearing <= w_half[OUT_W-1:0];
        r_turn    <= (w_mag[DB_W-1:0] > r_deadband);
    end

    assign o_valid            = r_vld[STAGES-1];
    assign o_bearing_centideg = r_bearing;
    assign o_turn_needed      = r_turn;

`ifndef SYNTHESIS
    // every accepted triple yields its result strobe
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_valid)
        else $error("result strobe missing after accepted word");

    // bearing stays within half of three quarter turns
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bearing_centideg <= BEARING_MAX &&
                     o_bearing_centideg >= -BEARING_MAX))
        else $error("bearing out of range");

    // a turn is never flagged for a zero bearing
    a_turn_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_turn_needed) |-> (o_bearing_centideg != '0))
        else $error("turn flagged with zero bearing");

    // table index stays inside the table
    a_idx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (32'(r_idx) <= 32'(ACOS_TABLE_SIZE - 1)))
        else $error("table index out of range");
`endif

endmodule
